[rtl/triangle_unit_normal_core_macros.svh]
// Assertion macros shared by the triangle unit normal RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef TRIANGLE_UNIT_NORMAL_CORE_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define TUN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tun assertion failed");
`define TUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tun assertion failed");
`else
`define TUN_ASSERT(lbl, clk, rst_n, prop)
`define TUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/tun_pkg.sv]
// Package of the triangle unit normal block: widths, payload types.
// Used by the front, back and top RTL files of the block; depends on nothing.
package tun_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 14;
    localparam int OUT_BITS    = 16;
    localparam int EDGE_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * EDGE_BITS;
    localparam int CROSS_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS    = PROD_BITS;
    localparam int SUM_BITS    = 2 * MAG_BITS + 2;
    localparam int ROOT_BITS   = SUM_BITS / 2;
    localparam int REM_BITS    = ROOT_BITS + 2;
    localparam int QUOT_BITS   = FRAC_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] p0_x;
        logic signed [COORD_BITS-1:0] p0_y;
        logic signed [COORD_BITS-1:0] p0_z;
        logic signed [COORD_BITS-1:0] p1_x;
        logic signed [COORD_BITS-1:0] p1_y;
        logic signed [COORD_BITS-1:0] p1_z;
        logic signed [COORD_BITS-1:0] p2_x;
        logic signed [COORD_BITS-1:0] p2_y;
        logic signed [COORD_BITS-1:0] p2_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [CROSS_BITS-1:0] cx;
        logic signed [CROSS_BITS-1:0] cy;
        logic signed [CROSS_BITS-1:0] cz;
    } t_cross;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] norm_x;
        logic signed [OUT_BITS-1:0] norm_y;
        logic signed [OUT_BITS-1:0] norm_z;
        logic                       degenerate;
    } t_norm_out;

endpackage

[rtl/tun_queue.sv]
// Small first-in first-out queue of flip-flops with push/full, pop/empty.
// Depends on the assertion macro header.
`include "triangle_unit_normal_core_macros.svh"
module tun_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `TUN_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `TUN_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !do_push && !do_pop, $stable(r_count))
    `TUN_ASSERT_NEXT(a_pop_only, i_clk, i_rst_n, do_pop && !do_push, r_count == $past(r_count) - 1'b1)

endmodule

[rtl/tun_front.sv]
// Front part: takes triangles, forms both edges and their cross product.
// Depends on tun_pkg.
module tun_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tun_pkg::t_tri_in i_data,
    output logic            o_full,
    input  logic            i_ready,
    output logic            o_valid,
    output tun_pkg::t_cross o_data
);

    localparam int EB = tun_pkg::EDGE_BITS;
    localparam int PB = tun_pkg::PROD_BITS;
    localparam int XB = tun_pkg::CROSS_BITS;

    logic                 r_v1, r_v2, r_v3;
    logic signed [EB-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [PB-1:0] r_p [6];
    tun_pkg::t_cross      r_c;

    assign o_full  = !i_ready;
    assign o_valid = r_v3;
    assign o_data  = r_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ready) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready) begin
            r_ax <= EB'(i_data.p2_x) - EB'(i_data.p0_x);
            r_ay <= EB'(i_data.p2_y) - EB'(i_data.p0_y);
            r_az <= EB'(i_data.p2_z) - EB'(i_data.p0_z);
            r_bx <= EB'(i_data.p1_x) - EB'(i_data.p0_x);
            r_by <= EB'(i_data.p1_y) - EB'(i_data.p0_y);
            r_bz <= EB'(i_data.p1_z) - EB'(i_data.p0_z);
            r_p[0] <= PB'(r_ay) * PB'(r_bz);
            r_p[1] <= PB'(r_az) * PB'(r_by);
            r_p[2] <= PB'(r_az) * PB'(r_bx);
            r_p[3] <= PB'(r_ax) * PB'(r_bz);
            r_p[4] <= PB'(r_ax) * PB'(r_by);
            r_p[5] <= PB'(r_ay) * PB'(r_bx);
            r_c.cx <= XB'(r_p[0]) - XB'(r_p[1]);
            r_c.cy <= XB'(r_p[2]) - XB'(r_p[3]);
            r_c.cz <= XB'(r_p[4]) - XB'(r_p[5]);
        end
    end

endmodule

[rtl/tun_back.sv]
// Back part: squared length, bit-per-stage square root, and three
// bit-per-stage dividers that scale the cross product to unit length.
// Depends on tun_pkg.
module tun_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  tun_pkg::t_cross    i_data,
    output logic               o_valid,
    output tun_pkg::t_norm_out o_data
);

    localparam int MB = tun_pkg::MAG_BITS;
    localparam int SB = tun_pkg::SUM_BITS;
    localparam int RB = tun_pkg::ROOT_BITS;
    localparam int EB = tun_pkg::REM_BITS;
    localparam int QB = tun_pkg::QUOT_BITS;
    localparam int OB = tun_pkg::OUT_BITS;
    localparam int DB = RB + 1;

    // Magnitude and sign of each component.
    logic          r_va, r_vb;
    logic [MB-1:0] r_ma [3];
    logic [MB-1:0] r_mb [3];
    logic          r_sa [3];
    logic          r_sb [3];
    logic [SB-1:0] r_sq [3];

    // Square root stages; element zero holds the sum.
    logic          r_sv   [RB+1];
    logic [SB-1:0] r_rad  [RB+1];
    logic [EB-1:0] r_rem  [RB+1];
    logic [RB-1:0] r_root [RB+1];
    logic [MB-1:0] r_smag [RB+1][3];
    logic          r_ssgn [RB+1][3];
    logic          r_sdeg [RB+1];

    // Divider stages.
    logic          r_dv   [1:QB];
    logic [RB-1:0] r_droot[1:QB];
    logic [DB-1:0] r_drem [1:QB][3];
    logic [QB-1:0] r_q    [1:QB][3];
    logic          r_dsgn [1:QB][3];
    logic          r_ddeg [1:QB];

    logic signed [tun_pkg::CROSS_BITS-1:0] n_c [3];

    assign n_c[0] = i_data.cx;
    assign n_c[1] = i_data.cy;
    assign n_c[2] = i_data.cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_va    <= i_valid;
            r_vb    <= r_va;
            r_sv[0] <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sa[k] <= n_c[k][tun_pkg::CROSS_BITS-1];
                r_ma[k] <= n_c[k][tun_pkg::CROSS_BITS-1] ? MB'(-n_c[k]) : MB'(n_c[k]);
                r_sq[k] <= SB'(r_ma[k]) * SB'(r_ma[k]);
                r_mb[k] <= r_ma[k];
                r_sb[k] <= r_sa[k];
                r_smag[0][k] <= r_mb[k];
                r_ssgn[0][k] <= r_sb[k];
            end
            r_rad[0]  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_sdeg[0] <= (r_sq[0] == '0) && (r_sq[1] == '0) && (r_sq[2] == '0);
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar j = 1; j <= RB; j++) begin : g_sqrt
        logic [EB-1:0] n_acc, n_trial;
        logic          n_take;

        assign n_acc   = {r_rem[j-1][EB-3:0], r_rad[j-1][SB-1 -: 2]};
        assign n_trial = {r_root[j-1], 2'b01};
        assign n_take  = (n_acc >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (i_en) begin
                r_sv[j] <= r_sv[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j]  <= r_rad[j-1] << 2;
                r_rem[j]  <= n_take ? n_acc - n_trial : n_acc;
                r_root[j] <= {r_root[j-1][RB-2:0], n_take};
                r_smag[j] <= r_smag[j-1];
                r_ssgn[j] <= r_ssgn[j-1];
                r_sdeg[j] <= r_sdeg[j-1];
            end
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_div
        logic [DB-1:0] n_num [3];
        logic [DB-1:0] n_den;
        logic          n_take [3];

        if (j == 1) begin : g_first
            assign n_den = DB'(r_root[RB]);
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign n_num[k]  = DB'(r_smag[RB][k]);
                assign n_take[k] = (n_num[k] >= n_den);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[j] <= 1'b0;
                end else if (i_en) begin
                    r_dv[j] <= r_sv[RB];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_droot[j] <= r_root[RB];
                    r_ddeg[j]  <= r_sdeg[RB];
                    for (int k = 0; k < 3; k++) begin
                        r_drem[j][k] <= n_take[k] ? n_num[k] - n_den : n_num[k];
                        r_q[j][k]    <= QB'(n_take[k]);
                        r_dsgn[j][k] <= r_ssgn[RB][k];
                    end
                end
            end
        end else begin : g_rest
            assign n_den = DB'(r_droot[j-1]);
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign n_num[k]  = {r_drem[j-1][k][DB-2:0], 1'b0};
                assign n_take[k] = (n_num[k] >= n_den);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[j] <= 1'b0;
                end else if (i_en) begin
                    r_dv[j] <= r_dv[j-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_droot[j] <= r_droot[j-1];
                    r_ddeg[j]  <= r_ddeg[j-1];
                    for (int k = 0; k < 3; k++) begin
                        r_drem[j][k] <= n_take[k] ? n_num[k] - n_den : n_num[k];
                        r_q[j][k]    <= {r_q[j-1][k][QB-2:0], n_take[k]};
                        r_dsgn[j][k] <= r_dsgn[j-1][k];
                    end
                end
            end
        end
    end

    // Apply the sign and clamp into the output range.
    localparam logic [31:0] LIM = 32'd1 << (OB - 1);
    logic signed [OB-1:0] n_out [3];

    always_comb begin
        logic [31:0] mag;
        for (int k = 0; k < 3; k++) begin
            mag = 32'(r_q[QB][k]);
            if (mag > LIM) begin
                mag = LIM;
            end
            if (r_ddeg[QB]) begin
                n_out[k] = '0;
            end else if (r_dsgn[QB][k]) begin
                n_out[k] = OB'(-mag);
            end else if (mag == LIM) begin
                n_out[k] = OB'(LIM - 32'd1);
            end else begin
                n_out[k] = OB'(mag);
            end
        end
    end

    assign o_valid           = r_dv[QB];
    assign o_data.norm_x     = n_out[0];
    assign o_data.norm_y     = n_out[1];
    assign o_data.norm_z     = n_out[2];
    assign o_data.degenerate = r_ddeg[QB];

endmodule

[rtl/triangle_unit_normal_core.sv]
// Top level of the triangle unit normal block: front, middle queue, back, result queue.
// Depends on tun_pkg, tun_queue, tun_front, tun_back and the macro header.
`include "triangle_unit_normal_core_macros.svh"
// The block takes one triangle per clock while full is low, through a push/full
// queue port, and returns its unit face normal in signed Q1.14 through an
// empty/pop port, one result per triangle, in order. It sustains one transfer
// per cycle on both sides while full is low and results are popped. Each result
// runs through the square root (one result bit per stage, 27 stages), the scaling
// dividers (one quotient bit per stage, 15 stages) and six arithmetic stages.
// The front part forms edges and the cross product; a small queue separates
// it from the back part, so a stalled result side first fills the result
// queue, then the middle queue, and only then raises full. Collinear or
// coincident vertices give a zero normal with the degenerate flag set.
module triangle_unit_normal_core #(
    parameter int QUEUE_DEPTH = tun_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tun_pkg::t_tri_in   i_tri,
    output logic               empty,
    input  logic               pop,
    output tun_pkg::t_norm_out o_norm
);

    localparam int XW = $bits(tun_pkg::t_cross);
    localparam int NW = $bits(tun_pkg::t_norm_out);

    logic            f_valid;
    tun_pkg::t_cross f_data;
    logic            mid_push, mid_full, mid_pop, mid_empty;
    logic [XW-1:0]   mid_out;
    logic            back_en, b_valid, out_push, out_full;
    tun_pkg::t_norm_out b_data;
    logic [NW-1:0]   out_data;

    // The front advances whenever the middle queue has room.
    tun_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_tri),
        .o_full  (full),
        .i_ready (!mid_full),
        .o_valid (f_valid),
        .o_data  (f_data)
    );

    assign mid_push = f_valid && !mid_full;

    tun_queue #(.WIDTH(XW), .DEPTH(QUEUE_DEPTH)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (f_data),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_out)
    );

    // The back pipeline moves as a whole whenever the result queue has room.
    assign back_en = !out_full;
    assign mid_pop = back_en && !mid_empty;

    tun_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (!mid_empty),
        .i_data  (tun_pkg::t_cross'(mid_out)),
        .o_valid (b_valid),
        .o_data  (b_data)
    );

    assign out_push = b_valid && back_en;

    tun_queue #(.WIDTH(NW), .DEPTH(tun_pkg::OUT_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (b_data),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_data)
    );

    assign o_norm = tun_pkg::t_norm_out'(out_data);

    // A degenerate result always carries a zero vector.
    `TUN_ASSERT(a_degen_zero, i_clk, i_rst_n, (!empty && o_norm.degenerate) |-> (o_norm.norm_x == '0 && o_norm.norm_y == '0 && o_norm.norm_z == '0))

endmodule

[verif/triangle_unit_normal_core_tb.sv]
// Testbench for triangle_unit_normal_core: drives triangles through the push/full port,
// predicts each unit normal with exact integer math and checks every popped result.
// Depends on tun_pkg and the RTL of the block.
`timescale 1ns / 100ps
module triangle_unit_normal_core_tb;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    tun_pkg::t_tri_in      i_tri;
    logic                  empty;
    logic                  pop;
    tun_pkg::t_norm_out    o_norm;

    // Expected normals, oldest first.
    tun_pkg::t_norm_out normals_due[$];
    int        err_count;
    // Idle percentage of each side; zero gives a stretch with no gaps.
    int        push_idle_pct;
    int        pop_idle_pct;

    triangle_unit_normal_core i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .push   (push),
        .full   (full),
        .i_tri  (i_tri),
        .empty  (empty),
        .pop    (pop),
        .o_norm (o_norm)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Scales one cross product component to Q1.14 with truncation toward zero,
    // saturating to the 16-bit output range.
    function automatic logic signed [tun_pkg::OUT_BITS-1:0] scale_comp(longint c,
                                                                        longint root);
        longint mag;
        longint q;
        mag = (c < 0) ? -c : c;
        q   = (mag <<< tun_pkg::FRAC_BITS) / root;
        if (c < 0) begin
            q = -q;
        end
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        return q[tun_pkg::OUT_BITS-1:0];
    endfunction

    // Exact unit normal of one triangle. The sum of squares fits in 64 bits
    // unsigned for 12-bit coordinates (each |c| < 2^26).
    function automatic tun_pkg::t_norm_out unit_normal(tun_pkg::t_tri_in t);
        longint ax, ay, az, bx, by, bz, cx, cy, cz;
        longint unsigned sum_sq;
        longint unsigned root;
        longint unsigned trial;
        tun_pkg::t_norm_out r;
        ax = longint'(t.p2_x) - longint'(t.p0_x);
        ay = longint'(t.p2_y) - longint'(t.p0_y);
        az = longint'(t.p2_z) - longint'(t.p0_z);
        bx = longint'(t.p1_x) - longint'(t.p0_x);
        by = longint'(t.p1_y) - longint'(t.p0_y);
        bz = longint'(t.p1_z) - longint'(t.p0_z);
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        sum_sq = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
        r = '0;
        if (sum_sq == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        // Bitwise square root, most significant result bit first.
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sum_sq) begin
                root = trial;
            end
        end
        r.norm_x = scale_comp(cx, root);
        r.norm_y = scale_comp(cy, root);
        r.norm_z = scale_comp(cz, root);
        return r;
    endfunction

    // Sends one triangle, waiting out full, and queues its expected normal.
    // Push stays high after the transfer so that the next call can follow
    // directly; the caller drops it once the last triangle is sent.
    task automatic send_triangle(tun_pkg::t_tri_in t);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_tri <= t;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        normals_due.push_back(unit_normal(t));
    endtask

    function automatic tun_pkg::t_tri_in random_triangle();
        logic [127:0]     raw;
        tun_pkg::t_tri_in t;
        raw = {$urandom, $urandom, $urandom, $urandom};
        t   = raw[$bits(tun_pkg::t_tri_in)-1:0];
        return t;
    endfunction

    // Result checker: pop is redrawn every cycle, results compare at the edge.
    always @(posedge i_clk) begin
        tun_pkg::t_norm_out exp_n;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (normals_due.size() == 0) begin
                    $error("result with no triangle outstanding");
                    err_count++;
                end else begin
                    exp_n = normals_due.pop_front();
                    if (o_norm.norm_x !== exp_n.norm_x) begin
                        $error("norm_x expected %0d actual %0d", exp_n.norm_x, o_norm.norm_x);
                        err_count++;
                    end
                    if (o_norm.norm_y !== exp_n.norm_y) begin
                        $error("norm_y expected %0d actual %0d", exp_n.norm_y, o_norm.norm_y);
                        err_count++;
                    end
                    if (o_norm.norm_z !== exp_n.norm_z) begin
                        $error("norm_z expected %0d actual %0d", exp_n.norm_z, o_norm.norm_z);
                        err_count++;
                    end
                    if (o_norm.degenerate !== exp_n.degenerate) begin
                        $error("degenerate expected %0b actual %0b",
                               exp_n.degenerate, o_norm.degenerate);
                        err_count++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // Corners of the coordinate range, degenerate shapes and axis-aligned faces.
    task automatic test_directed();
        tun_pkg::t_tri_in t;
        t = '0;
        send_triangle(t);                       // all vertices coincide
        t = '{12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd1, 12'sd1, 12'sd2, 12'sd2, 12'sd2};
        send_triangle(t);                       // collinear vertices
        t = '{12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd0};
        send_triangle(t);                       // face in the xy plane
        t = '{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd0, 12'sd0, 12'sd0, 12'sd1};
        send_triangle(t);
        t = '{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd1, 12'sd1, 12'sd0, 12'sd0};
        send_triangle(t);
        // Largest edges: opposite corners of the coordinate cube.
        t = '{-12'sd2048, -12'sd2048, -12'sd2048, 12'sd2047, -12'sd2048, -12'sd2048,
              -12'sd2048, 12'sd2047, 12'sd2047};
        send_triangle(t);
        t = '{12'sd2047, 12'sd2047, 12'sd2047, -12'sd2048, 12'sd2047, -12'sd2048,
              12'sd2047, -12'sd2048, -12'sd2048};
        send_triangle(t);
        t = '{-12'sd2048, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 12'sd2047,
              -12'sd2048, -12'sd2048, 12'sd2047};
        send_triangle(t);
        // Tiny face far from the origin and a sliver with very uneven edges.
        t = '{12'sd2046, -12'sd2047, 12'sd2047, 12'sd2047, -12'sd2047, 12'sd2047,
              12'sd2046, -12'sd2048, 12'sd2047};
        send_triangle(t);
        t = '{-12'sd2048, 12'sd0, 12'sd0, 12'sd2047, 12'sd0, 12'sd0, 12'sd2047, 12'sd1, 12'sd0};
        send_triangle(t);
        t = '{12'sd5, -12'sd7, 12'sd3, 12'sd5, -12'sd7, 12'sd3, -12'sd900, 12'sd11, 12'sd4};
        send_triangle(t);                       // two coincident vertices
        t = '{12'sd1, 12'sd2, 12'sd3, -12'sd1, -12'sd2, -12'sd3, 12'sd1, 12'sd2, 12'sd3};
        send_triangle(t);
    endtask

    task automatic test_random(int count);
        tun_pkg::t_tri_in t;
        for (int n = 0; n < count; n++) begin
            t = random_triangle();
            case ($urandom_range(3))
                0: begin
                    // Pulls p1_x, p1_y and p2_z to within 3 of the matching p0 coordinates.
                    t.p1_x = t.p0_x + 12'($urandom_range(6)) - 12'sd3;
                    t.p1_y = t.p0_y + 12'($urandom_range(6)) - 12'sd3;
                    t.p2_z = t.p0_z + 12'($urandom_range(6)) - 12'sd3;
                end
                1: begin
                    // Collinear: p2 repeats the p0 to p1 step.
                    t.p0_x = 12'($signed(t.p0_x) >>> 2);
                    t.p0_y = 12'($signed(t.p0_y) >>> 2);
                    t.p0_z = 12'($signed(t.p0_z) >>> 2);
                    t.p1_x = t.p0_x + 12'($urandom_range(200)) - 12'sd100;
                    t.p1_y = t.p0_y + 12'($urandom_range(200)) - 12'sd100;
                    t.p1_z = t.p0_z + 12'($urandom_range(200)) - 12'sd100;
                    t.p2_x = 12'sd2 * t.p1_x - t.p0_x;
                    t.p2_y = 12'sd2 * t.p1_y - t.p0_y;
                    t.p2_z = 12'sd2 * t.p1_z - t.p0_z;
                end
                default: ;
            endcase
            send_triangle(t);
        end
    endtask

    initial begin
        err_count     = 0;
        push_idle_pct = 10;
        pop_idle_pct  = 10;
        i_rst_n       = 1'b0;
        push          = 1'b0;
        i_tri         = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(400);
        // Back-to-back transfers on both sides.
        push_idle_pct = 0;
        pop_idle_pct  = 0;
        test_random(300);
        // Random gaps on both sides again; now and then the result side backs
        // up far enough to raise full.
        pop_idle_pct  = 10;
        push_idle_pct = 10;
        test_random(300);
        push <= 1'b0;

        while (normals_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
